>>> rtl/core/pulse_oximetry_beat_spo2_defines.svh
// Assertion macros for the pulse oximetry beat and SpO2 block.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef PULSE_OXIMETRY_BEAT_SPO2_DEFINES_SVH
`define PULSE_OXIMETRY_BEAT_SPO2_DEFINES_SVH

// Same-cycle implication.
`define POX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define POX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pox_pkg.sv
// Shared widths, constants and types for the pulse oximetry block.
// No dependencies.
package pox_pkg;

  localparam int unsigned SAMPLE_W   = 18;
  localparam int unsigned SLOPE_W    = 25;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned SAT_W      = 15;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned REFR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Running sums stay below 2**SUM_W for every supported window.
  localparam int unsigned SUM_W  = 27;
  localparam int unsigned MUL_W  = 29;
  localparam int unsigned PROD_W = SUM_W + MUL_W;

  localparam int unsigned SMOOTH_WIN_DEF = 4;
  localparam int unsigned BASE_WIN_DEF   = 32;
  localparam int unsigned PERIOD_WIN_DEF = 8;
  localparam int unsigned SPO2_WIN_DEF   = 8;
  localparam int unsigned DELAY_TAPS_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 1'd1;

  localparam logic [REFR_W-1:0] REFR_RESET = 16'd25;
  localparam logic [TEMP_W-1:0] TEMP_RESET = 12'd400;
  localparam int                TEMP_REF   = 400;

  localparam logic [13:0] SPO2_A   = 14'd10400;
  localparam logic [10:0] SPO2_B   = 11'd1700;
  localparam logic [13:0] SPO2_MIN = 14'd5000;
  localparam logic [13:0] SPO2_MAX = 14'd10000;

  // Quotient limits: above HI_Q the value clamps low, below LO_Q it clamps high.
  localparam int unsigned QUO_W = 15;
  localparam logic [QUO_W-1:0] HI_Q = 15'd5400;
  localparam logic [QUO_W-1:0] LO_Q = 15'd400;

  localparam int unsigned DC_W  = SAMPLE_W + 1;
  localparam int unsigned ND_W  = DC_W + SAMPLE_W;
  localparam int unsigned NUM_W = ND_W + 12;

  typedef struct packed {
    logic [SAMPLE_W-1:0]       sir;
    logic [SAMPLE_W-1:0]       sred;
    logic                      beat;
    logic signed [SLOPE_W-1:0] slope;
    logic [REFR_W-1:0]         since;
  } pox_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pox_qstat_t;

endpackage

>>> rtl/core/pulse_oximetry_beat_spo2.sv
// Pulse oximetry beat detection and SpO2 top level: config registers, front, queue, back.
// Front steps through multiply, subtract, average and push states for each sample; back
// runs multiply, subtract and output, plus beat, check, the 15-step quotient loop of the SpO2
// ratio and saturation states on a beat sample. Front stalls input until the sample is pushed.
// Asynchronous active-low reset clears the running sums, trackers and the delay line; no sweep.
`include "pulse_oximetry_beat_spo2_defines.svh"
module pulse_oximetry_beat_spo2
  import pox_pkg::*;
#(
  parameter int unsigned SMOOTH_WIN = SMOOTH_WIN_DEF,
  parameter int unsigned BASE_WIN   = BASE_WIN_DEF,
  parameter int unsigned PERIOD_WIN = PERIOD_WIN_DEF,
  parameter int unsigned SPO2_WIN   = SPO2_WIN_DEF,
  parameter int unsigned DELAY_TAPS = DELAY_TAPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [SAMPLE_W-1:0]       ir_sample_i,
  input  logic [SAMPLE_W-1:0]       red_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [SAMPLE_W-1:0]       smooth_ir_o,
  output logic [SAMPLE_W-1:0]       smooth_red_o,
  output logic                      beat_o,
  output logic signed [SLOPE_W-1:0] slope_o,
  output logic [PERIOD_W-1:0]       period_average_o,
  output logic signed [SAT_W-1:0]   oxygen_saturation_o
);

  logic [REFR_W-1:0]        refr_q;
  logic signed [TEMP_W-1:0] temp_q;

  logic       q_push, q_pop;
  pox_item_t  push_item, pop_item;
  pox_qstat_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_q <= REFR_RESET;
      temp_q <= TEMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REFRACTORY: refr_q <= cfg_data_i[REFR_W-1:0];
        CFG_TEMP:       temp_q <= cfg_data_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  pox_front #(
    .SMOOTH_WIN (SMOOTH_WIN),
    .DELAY_TAPS (DELAY_TAPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .refractory_i (refr_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ir_sample_i  (ir_sample_i),
    .red_sample_i (red_sample_i),
    .qstat_i      (qstat),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  pox_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .qstat_o (qstat)
  );

  pox_back #(
    .BASE_WIN   (BASE_WIN),
    .PERIOD_WIN (PERIOD_WIN),
    .SPO2_WIN   (SPO2_WIN)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .temp_i              (temp_q),
    .qstat_i             (qstat),
    .q_item_i            (pop_item),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .smooth_ir_o         (smooth_ir_o),
    .smooth_red_o        (smooth_red_o),
    .beat_o              (beat_o),
    .slope_o             (slope_o),
    .period_average_o    (period_average_o),
    .oxygen_saturation_o (oxygen_saturation_o)
  );

  `POX_ASSERT_IMP(a_push_room, q_push, !qstat.full, "queue word pushed while full")
  `POX_ASSERT_IMP(a_pop_data, q_pop, !qstat.empty, "queue word popped while empty")
  `POX_ASSERT_NXT(a_front_busy, in_valid_i && !in_stall_o, in_stall_o, "front took two words")

endmodule

>>> rtl/core/pox_front.sv
// Front part: smoothing, slope delay line and beat classification.
// Depends on pox_pkg; pushes one word per sample into pox_queue.
module pox_front
  import pox_pkg::*;
#(
  parameter int unsigned SMOOTH_WIN = SMOOTH_WIN_DEF,
  parameter int unsigned DELAY_TAPS = DELAY_TAPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [REFR_W-1:0]   refractory_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] ir_sample_i,
  input  logic [SAMPLE_W-1:0] red_sample_i,
  input  pox_qstat_t          qstat_i,
  output logic                q_push_o,
  output pox_item_t           q_item_o
);

  localparam int unsigned D_LK = SMOOTH_WIN + 1;
  localparam int unsigned K_LK = SUM_W + $clog2(D_LK);
  localparam logic [MUL_W-1:0] M_LK = MUL_W'(((64'd1 << K_LK) + D_LK - 1) / D_LK);
  localparam int unsigned K_AV = SUM_W + $clog2(SMOOTH_WIN);
  localparam logic [MUL_W-1:0] M_AV =
    MUL_W'(((64'd1 << K_AV) + SMOOTH_WIN - 1) / SMOOTH_WIN);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_SUB  = 5'b00100,
    F_AVG  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [SUM_W-1:0]          ir_sum_q, red_sum_q;
  logic [SUM_W-1:0]          acc_ir_q, acc_red_q;
  logic [PROD_W-1:0]         prod_ir_q, prod_red_q;
  logic [SUM_W-1:0]          delay_q [DELAY_TAPS];
  logic signed [SLOPE_W-1:0] prev_slope_q;
  logic [REFR_W-1:0]         since_q;

  logic signed [SLOPE_W-1:0] slope;
  logic [REFR_W-1:0]         since_inc;
  logic                      beat;

  assign slope     = $signed(SLOPE_W'(ir_sum_q) - SLOPE_W'(delay_q[DELAY_TAPS-1]));
  assign since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
  assign beat      = slope[SLOPE_W-1] && !prev_slope_q[SLOPE_W-1] && (prev_slope_q != '0)
                     && (since_inc > refractory_i);

  assign in_stall_o = (state_q != F_IDLE);
  assign q_push_o   = (state_q == F_PUSH) && !qstat_i.full;

  assign q_item_o.sir   = SAMPLE_W'(prod_ir_q >> K_AV);
  assign q_item_o.sred  = SAMPLE_W'(prod_red_q >> K_AV);
  assign q_item_o.beat  = beat;
  assign q_item_o.slope = slope;
  assign q_item_o.since = since_inc;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_MUL;
      F_MUL:  state_d = F_SUB;
      F_SUB:  state_d = F_AVG;
      F_AVG:  state_d = F_PUSH;
      F_PUSH: if (!qstat_i.full) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      ir_sum_q     <= '0;
      red_sum_q    <= '0;
      prev_slope_q <= '0;
      since_q      <= '0;
      for (int i = 0; i < DELAY_TAPS; i++) delay_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_SUB) begin
        ir_sum_q  <= acc_ir_q - SUM_W'(prod_ir_q >> K_LK);
        red_sum_q <= acc_red_q - SUM_W'(prod_red_q >> K_LK);
      end
      if (q_push_o) begin
        prev_slope_q <= slope;
        since_q      <= beat ? '0 : since_inc;
        for (int i = DELAY_TAPS - 1; i > 0; i--) delay_q[i] <= delay_q[i-1];
        delay_q[0] <= ir_sum_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      acc_ir_q  <= ir_sum_q + SUM_W'(ir_sample_i);
      acc_red_q <= red_sum_q + SUM_W'(red_sample_i);
    end
    if (state_q == F_MUL) begin
      prod_ir_q  <= PROD_W'(acc_ir_q) * PROD_W'(M_LK);
      prod_red_q <= PROD_W'(acc_red_q) * PROD_W'(M_LK);
    end
    if (state_q == F_AVG) begin
      prod_ir_q  <= PROD_W'(ir_sum_q) * PROD_W'(M_AV);
      prod_red_q <= PROD_W'(red_sum_q) * PROD_W'(M_AV);
    end
  end

endmodule

>>> rtl/core/pox_queue.sv
// Two-entry queue between front and back parts.
// Depends on pox_pkg for the word type.
module pox_queue
  import pox_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pox_item_t  item_i,
  input  logic       pop_i,
  output pox_item_t  item_o,
  output pox_qstat_t qstat_o
);

  pox_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);
  assign item_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

>>> rtl/core/pox_back.sv
// Back part: baselines, min/max, period and SpO2 averaging, output register.
// Depends on pox_pkg; pops words from pox_queue.
module pox_back
  import pox_pkg::*;
#(
  parameter int unsigned BASE_WIN   = BASE_WIN_DEF,
  parameter int unsigned PERIOD_WIN = PERIOD_WIN_DEF,
  parameter int unsigned SPO2_WIN   = SPO2_WIN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [TEMP_W-1:0]   temp_i,
  input  pox_qstat_t                 qstat_i,
  input  pox_item_t                  q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [SAMPLE_W-1:0]        smooth_ir_o,
  output logic [SAMPLE_W-1:0]        smooth_red_o,
  output logic                       beat_o,
  output logic signed [SLOPE_W-1:0]  slope_o,
  output logic [PERIOD_W-1:0]        period_average_o,
  output logic signed [SAT_W-1:0]    oxygen_saturation_o
);

  localparam int unsigned D_BL = BASE_WIN + 1;
  localparam int unsigned K_BL = SUM_W + $clog2(D_BL);
  localparam logic [MUL_W-1:0] M_BL = MUL_W'(((64'd1 << K_BL) + D_BL - 1) / D_BL);
  localparam int unsigned K_BD = SUM_W + $clog2(BASE_WIN);
  localparam logic [MUL_W-1:0] M_BD = MUL_W'(((64'd1 << K_BD) + BASE_WIN - 1) / BASE_WIN);
  localparam int unsigned D_PL = PERIOD_WIN + 1;
  localparam int unsigned K_PL = SUM_W + $clog2(D_PL);
  localparam logic [MUL_W-1:0] M_PL = MUL_W'(((64'd1 << K_PL) + D_PL - 1) / D_PL);
  localparam int unsigned K_PA = SUM_W + $clog2(PERIOD_WIN);
  localparam logic [MUL_W-1:0] M_PA =
    MUL_W'(((64'd1 << K_PA) + PERIOD_WIN - 1) / PERIOD_WIN);
  localparam int unsigned D_QL = SPO2_WIN + 1;
  localparam int unsigned K_QL = SUM_W + $clog2(D_QL);
  localparam logic [MUL_W-1:0] M_QL = MUL_W'(((64'd1 << K_QL) + D_QL - 1) / D_QL);
  localparam int unsigned K_QA = SUM_W + $clog2(SPO2_WIN);
  localparam logic [MUL_W-1:0] M_QA = MUL_W'(((64'd1 << K_QA) + SPO2_WIN - 1) / SPO2_WIN);
  localparam int unsigned DSH_W = ND_W + QUO_W;

  typedef enum logic [12:0] {
    B_IDLE  = 13'b0000000000001,
    B_MUL   = 13'b0000000000010,
    B_SUB   = 13'b0000000000100,
    B_BEAT1 = 13'b0000000001000,
    B_BEAT2 = 13'b0000000010000,
    B_BEAT3 = 13'b0000000100000,
    B_CHK   = 13'b0000001000000,
    B_DIV   = 13'b0000010000000,
    B_SAT   = 13'b0000100000000,
    B_SATM  = 13'b0001000000000,
    B_SATS  = 13'b0010000000000,
    B_FIN   = 13'b0100000000000,
    B_OUT   = 13'b1000000000000
  } back_state_e;

  back_state_e state_q, state_d;

  pox_item_t          cur_q;
  logic [SAMPLE_W-1:0] ir_hi_q, ir_lo_q, red_hi_q, red_lo_q;
  logic [SUM_W-1:0]   base_ir_q, base_red_q, bacc_ir_q, bacc_red_q;
  logic [PROD_W-1:0]  bprod_ir_q, bprod_red_q;
  logic [SUM_W-1:0]   period_q, pacc_q, sat_q, sacc_q;
  logic [PROD_W-1:0]  pprod_q, sprod_q, pavg_q, savg_q;
  logic [ND_W-1:0]    n_q, d_q;
  logic [NUM_W-1:0]   num_q;
  logic               big_q, skip_q;
  logic [QUO_W-1:0]   quo_q;
  logic [3:0]         bit_q;
  logic               out_valid_q;

  logic [SAMPLE_W-1:0] ac_ir, ac_red;
  logic [DC_W-1:0]     dc_ir, dc_red;
  logic [DSH_W-1:0]    dsh;
  logic                fits;
  logic [13:0]         spo2;
  logic                load_out;
  logic signed [13:0]  tdiff, t3, corr;
  logic [13:0]         sat_avg;
  logic signed [15:0]  sat_out;

  assign ac_ir  = ir_hi_q - ir_lo_q;
  assign ac_red = red_hi_q - red_lo_q;
  assign dc_ir  = DC_W'(bprod_ir_q >> K_BD);
  assign dc_red = DC_W'(bprod_red_q >> K_BD);
  assign dsh    = DSH_W'(d_q) << bit_q;
  assign fits   = DSH_W'(num_q) >= dsh;

  always_comb begin
    if (big_q || quo_q > HI_Q) spo2 = SPO2_MIN;
    else if (quo_q < LO_Q)     spo2 = SPO2_MAX;
    else                       spo2 = SPO2_A - 14'(quo_q);
  end

  assign tdiff   = 14'(temp_i) - 14'sd400;
  assign t3      = (tdiff <<< 1) + tdiff;
  assign corr    = t3 >>> 2;
  assign sat_avg = 14'(savg_q >> K_QA);
  assign sat_out = $signed(16'(sat_avg)) + 16'(corr);

  assign q_pop_o     = (state_q == B_IDLE) && !qstat_i.empty;
  assign load_out    = (state_q == B_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!qstat_i.empty) state_d = B_MUL;
      B_MUL:   state_d = B_SUB;
      B_SUB:   state_d = cur_q.beat ? B_BEAT1 : B_OUT;
      B_BEAT1: state_d = B_BEAT2;
      B_BEAT2: state_d = B_BEAT3;
      B_BEAT3: state_d = skip_q ? B_FIN : B_CHK;
      B_CHK:   state_d = B_DIV;
      B_DIV:   if (big_q || bit_q == '0) state_d = B_SAT;
      B_SAT:   state_d = B_SATM;
      B_SATM:  state_d = B_SATS;
      B_SATS:  state_d = B_FIN;
      B_FIN:   state_d = B_OUT;
      B_OUT:   if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      ir_hi_q     <= '0;
      red_hi_q    <= '0;
      ir_lo_q     <= '1;
      red_lo_q    <= '1;
      base_ir_q   <= '0;
      base_red_q  <= '0;
      period_q    <= '0;
      sat_q       <= '0;
      pavg_q      <= '0;
      savg_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (q_pop_o) begin
        if (q_item_i.sir > ir_hi_q) ir_hi_q <= q_item_i.sir;
        if (q_item_i.sred > red_hi_q) red_hi_q <= q_item_i.sred;
        if (q_item_i.sir < ir_lo_q) ir_lo_q <= q_item_i.sir;
        if (q_item_i.sred < red_lo_q) red_lo_q <= q_item_i.sred;
      end
      if (state_q == B_SUB) begin
        base_ir_q  <= bacc_ir_q - SUM_W'(bprod_ir_q >> K_BL);
        base_red_q <= bacc_red_q - SUM_W'(bprod_red_q >> K_BL);
      end
      if (state_q == B_BEAT3) begin
        period_q <= pacc_q - SUM_W'(pprod_q >> K_PL);
        ir_hi_q  <= '0;
        red_hi_q <= '0;
        ir_lo_q  <= '1;
        red_lo_q <= '1;
      end
      if (state_q == B_SATS) sat_q <= sacc_q - SUM_W'(sprod_q >> K_QL);
      if (state_q == B_FIN) begin
        pavg_q <= PROD_W'(period_q) * PROD_W'(M_PA);
        savg_q <= PROD_W'(sat_q) * PROD_W'(M_QA);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q     <= q_item_i;
      bacc_ir_q  <= base_ir_q + SUM_W'(q_item_i.sir);
      bacc_red_q <= base_red_q + SUM_W'(q_item_i.sred);
    end
    if (state_q == B_MUL) begin
      bprod_ir_q  <= PROD_W'(bacc_ir_q) * PROD_W'(M_BL);
      bprod_red_q <= PROD_W'(bacc_red_q) * PROD_W'(M_BL);
    end
    if (state_q == B_BEAT1) begin
      bprod_ir_q  <= PROD_W'(base_ir_q) * PROD_W'(M_BD);
      bprod_red_q <= PROD_W'(base_red_q) * PROD_W'(M_BD);
      pacc_q      <= period_q + SUM_W'(cur_q.since);
    end
    if (state_q == B_BEAT2) begin
      n_q     <= ND_W'(ac_red) * ND_W'(dc_ir);
      d_q     <= ND_W'(dc_red) * ND_W'(ac_ir);
      skip_q  <= (dc_ir == '0) || (dc_red == '0) || (ac_ir == '0);
      pprod_q <= PROD_W'(pacc_q) * PROD_W'(M_PL);
    end
    if (state_q == B_BEAT3) num_q <= NUM_W'(n_q) * NUM_W'(SPO2_B) + NUM_W'(d_q) - 1'b1;
    if (state_q == B_CHK) begin
      big_q <= DSH_W'(num_q) >= {d_q, {QUO_W{1'b0}}};
      quo_q <= '0;
      bit_q <= 4'(QUO_W - 1);
    end
    if (state_q == B_DIV) begin
      if (fits) begin
        num_q        <= num_q - NUM_W'(dsh);
        quo_q[bit_q] <= 1'b1;
      end
      bit_q <= bit_q - 1'b1;
    end
    if (state_q == B_SAT) sacc_q <= sat_q + SUM_W'(spo2);
    if (state_q == B_SATM) sprod_q <= PROD_W'(sacc_q) * PROD_W'(M_QL);
    if (load_out) begin
      smooth_ir_o         <= cur_q.sir;
      smooth_red_o        <= cur_q.sred;
      beat_o              <= cur_q.beat;
      slope_o             <= cur_q.slope;
      period_average_o    <= PERIOD_W'(pavg_q >> K_PA);
      oxygen_saturation_o <= SAT_W'(sat_out);
    end
  end

endmodule

>>> test/tb.sv
// Testbench for pulse_oximetry_beat_spo2: random and directed sample pairs,
// predicted by an in-bench model of smoothing, beat detection and SpO2.
// Depends on pox_pkg and the RTL top level.
module tb;
  import pox_pkg::*;

  localparam int unsigned SW = 4, BW = 32, PW = 8, OW = 8, DT = 4;

  typedef struct {
    logic [SAMPLE_W-1:0] sir;
    logic [SAMPLE_W-1:0] sred;
    logic                beat;
    logic [SLOPE_W-1:0]  slope;
    logic [PERIOD_W-1:0] pavg;
    logic [SAT_W-1:0]    sat;
  } word_t;

  class oximeter_board;
    bit [31:0] ir_s, red_s, ir_b, red_b, ir_lo, ir_hi, red_lo, red_hi;
    bit [31:0] per_s, since, sat_s, dly[DT];
    int        prev_slope;
    bit [15:0] refr;
    int        temp;
    word_t     pending[$];
    int        errors;

    function void clear();
      ir_s = 0; red_s = 0; ir_b = 0; red_b = 0;
      ir_lo = '1; red_lo = '1; ir_hi = 0; red_hi = 0;
      per_s = 0; since = 0; sat_s = 0; prev_slope = 0;
      foreach (dly[i]) dly[i] = 0;
      refr = 16'd25; temp = 400; errors = 0;
    endfunction

    function bit [31:0] leak(bit [31:0] s, bit [31:0] x, bit [31:0] w);
      s = s + x;
      return s - s / (w + 1);
    endfunction

    function void set_reg(bit idx, bit [15:0] v);
      if (idx == CFG_REFRACTORY) refr = v;
      else temp = $signed(v[11:0]);
    endfunction

    function void note_sample(bit [17:0] ir, bit [17:0] red);
      word_t     w;
      bit [31:0] sir, sred;
      longint    sl, q, s, n, d;
      bit        bt;
      ir_s = leak(ir_s, ir, SW);
      red_s = leak(red_s, red, SW);
      sir = ir_s / SW; sred = red_s / SW;
      if (sir > ir_hi) ir_hi = sir;
      if (sred > red_hi) red_hi = sred;
      if (sir < ir_lo) ir_lo = sir;
      if (sred < red_lo) red_lo = sred;
      ir_b = leak(ir_b, sir, BW);
      red_b = leak(red_b, sred, BW);
      if (since < 16'hFFFF) since++;
      sl = longint'(ir_s) - longint'(dly[DT-1]);
      for (int i = DT - 1; i > 0; i--) dly[i] = dly[i-1];
      dly[0] = ir_s;
      bt = (int'(sl) < 0) && (prev_slope > 0) && (since > refr);
      prev_slope = int'(sl);
      if (bt) begin
        per_s = leak(per_s, since, PW);
        since = 0;
        if (ir_b / BW != 0 && red_b / BW != 0 && ir_hi - ir_lo != 0) begin
          n = longint'(red_hi - red_lo) * longint'(ir_b / BW);
          d = longint'(red_b / BW) * longint'(ir_hi - ir_lo);
          q = (1700 * n + d - 1) / d;
          s = (q > 10400) ? 5000 : 10400 - q;
          if (s > 10000) s = 10000;
          if (s < 5000) s = 5000;
          sat_s = leak(sat_s, 32'(s), OW);
        end
        ir_lo = '1; red_lo = '1; ir_hi = 0; red_hi = 0;
      end
      w.sir = SAMPLE_W'(sir); w.sred = SAMPLE_W'(sred); w.beat = bt;
      w.slope = SLOPE_W'(sl);
      w.pavg = PERIOD_W'(per_s / PW);
      w.sat = SAT_W'(longint'(sat_s / OW) + longint'(((temp - 400) * 3 + 8192) / 4 - 2048));
      pending.push_back(w);
    endfunction

    function void check_word(word_t got);
      word_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.sir !== e.sir) begin
        $error("smooth_ir exp %0d got %0d", e.sir, got.sir); errors++;
      end
      if (got.sred !== e.sred) begin
        $error("smooth_red exp %0d got %0d", e.sred, got.sred); errors++;
      end
      if (got.beat !== e.beat) begin
        $error("beat exp %0d got %0d", e.beat, got.beat); errors++;
      end
      if (got.slope !== e.slope) begin
        $error("slope exp %h got %h", e.slope, got.slope); errors++;
      end
      if (got.pavg !== e.pavg) begin
        $error("period_average exp %0d got %0d", e.pavg, got.pavg); errors++;
      end
      if (got.sat !== e.sat) begin
        $error("oxygen_saturation exp %h got %h", e.sat, got.sat); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [SAMPLE_W-1:0] ir_sample_i = '0, red_sample_i = '0;
  logic in_stall_o, out_valid_o, beat_o;
  logic [SAMPLE_W-1:0] smooth_ir_o, smooth_red_o;
  logic signed [SLOPE_W-1:0] slope_o;
  logic [PERIOD_W-1:0] period_average_o;
  logic signed [SAT_W-1:0] oxygen_saturation_o;

  oximeter_board board = new();
  int idle_pct = 0, stall_pct = 0;
  real phase_t = 0.0;

  always #5 clk_i = ~clk_i;

  pulse_oximetry_beat_spo2 DUT (.*);

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      w.sir = smooth_ir_o; w.sred = smooth_red_o; w.beat = beat_o;
      w.slope = slope_o; w.pavg = period_average_o; w.sat = oxygen_saturation_o;
      board.check_word(w);
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(bit idx, bit [15:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(idx, v);
  endtask

  task automatic send_sample(bit [17:0] ir, bit [17:0] red);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; ir_sample_i <= ir; red_sample_i <= red;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_sample(ir, red);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // pulse-like waveform with random amplitude, period, DC level and noise, mixed with random samples
  task automatic send_pulses(int count);
    int per, amp, dc, rdc, rlvl;
    per = $urandom_range(40, 6);
    amp = $urandom_range(60000, 50);
    dc = $urandom_range(200000, 1000);
    rdc = $urandom_range(200000, 1000);
    rlvl = $urandom_range(100, 1);
    for (int i = 0; i < count; i++) begin
      int ph, ir, rd;
      if ($urandom_range(19) == 0) begin
        send_sample(18'($urandom), 18'($urandom));
        continue;
      end
      ph = i % per;
      ir = dc + ((ph < per / 2) ? amp * ph : amp * (per - ph)) / per
           + $urandom_range(rlvl);
      rd = rdc + ((ph < per / 2) ? amp * ph : amp * (per - ph)) / (2 * per)
           + $urandom_range(rlvl);
      if (ir > 262143) ir = 262143;
      if (rd > 262143) rd = 262143;
      send_sample(18'(ir), 18'(rd));
    end
  endtask

  initial begin
    board.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_sample(18'd0, 18'd0);
    send_sample(18'h3FFFF, 18'h3FFFF);
    send_sample(18'h3FFFF, 18'd0);
    send_sample(18'd0, 18'h3FFFF);
    for (int i = 0; i < 20; i++)
      send_sample((i % 6 < 3) ? 18'h3FFFF : 18'h100, (i % 4 < 2) ? 18'h2AAAA : 18'h15555);
    drain();
    write_reg(CFG_REFRACTORY, 16'd0);
    write_reg(CFG_TEMP, 16'(-640));
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 56; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 56; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      repeat (3) send_pulses(50);
      drain();
      case (ph)
        0: write_reg(CFG_TEMP, 16'd2000);
        1: write_reg(CFG_REFRACTORY, 16'hFFFF);
        2: write_reg(CFG_REFRACTORY, 16'($urandom_range(12, 1)));
        3: write_reg(CFG_TEMP, 16'($urandom_range(2000, 0) - 640));
        4: write_reg(CFG_TEMP, 16'd400);
        5: write_reg(CFG_REFRACTORY, 16'd25);
        default: write_reg(CFG_TEMP, 16'(-1));
      endcase
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
